/* rtl/core/bpiq_pkg.sv */
// Shared types and constants of the bandpass IQ envelope demodulator.
`timescale 1ns / 1ps
`default_nettype none

package bpiq_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned MAG_W          = 15;
  localparam int unsigned WIN_LEN_W      = 7;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 7;
  localparam int unsigned JOB_DEPTH      = 4;
  localparam int unsigned RES_DEPTH      = 2;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 7'd16;
  localparam logic [MAG_W-1:0]     MAG_MAX     = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_EVEN = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;
    logic [MAG_W-1:0]              magnitude;
    logic                          last;
  } out_item_t;

  // filtered I/Q pair for one frame position, front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] i_val;
    logic [SAMPLE_BITS-1:0] q_val;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic                     start;
    logic [2*SAMPLE_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/bpiq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/bpiq_fifo.sv */
// Small register FIFO used as job queue and result queue.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bpiq_front.sv */
// Front end: sample delay line, I/Q FIR taps, sign flips, job issue.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bpiq_pkg::in_item_t item_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               negate_even_i,
  output logic                    job_push_o,
  output bpiq_pkg::job_t          job_o,
  input  wire logic               job_full_i
);

  import bpiq_pkg::*;

  localparam int unsigned TAPS  = 7;
  localparam int unsigned POS_W = 8;
  localparam int unsigned J_W   = 2;
  localparam logic [POS_W-1:0] POS_LAST = 8'd255;
  localparam logic [POS_W-1:0] POS_WRAP = 8'd252;
  localparam logic [POS_W-1:0] POS_LAG  = 8'd3;
  localparam logic [J_W-1:0]   LAG_J    = 2'd3;

  logic [SAMPLE_BITS-1:0] dly_q [TAPS];
  logic [POS_W-1:0]       pos_q, job_p_q;
  logic [J_W-1:0]         job_j_q;
  logic                   busy_q, flush_q;
  logic                   accept;

  logic [POS_W-1:0]       n;
  logic [SAMPLE_BITS-1:0] tap_c, tap_a, tap_b, q_diff, i_raw, q_raw, i_val, q_val;
  logic                   i_ok, q_ok;

  assign full   = busy_q;
  assign accept = push && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        dly_q[k] <= '0;
      end
      pos_q   <= '0;
      job_p_q <= '0;
      job_j_q <= '0;
      busy_q  <= 1'b0;
      flush_q <= 1'b0;
    end else if (accept) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        dly_q[k] <= dly_q[k-1];
      end
      dly_q[0] <= item_i.sample;
      job_p_q  <= pos_q;
      flush_q  <= item_i.frame_end;
      if (item_i.frame_end) begin
        // flush every pending position, oldest first
        pos_q   <= '0;
        busy_q  <= 1'b1;
        job_j_q <= (pos_q >= POS_LAG) ? LAG_J : pos_q[J_W-1:0];
      end else begin
        pos_q   <= (pos_q == POS_LAST) ? POS_WRAP : pos_q + POS_W'(1);
        busy_q  <= (pos_q >= POS_LAG);
        job_j_q <= LAG_J;
      end
    end else if (busy_q && !job_full_i) begin
      if (flush_q && job_j_q != '0) begin
        job_j_q <= job_j_q - J_W'(1);
      end else begin
        busy_q <= 1'b0;
        if (flush_q) begin
          for (int k = 0; k < TAPS; k++) begin
            dly_q[k] <= '0;
          end
        end
      end
    end
  end

  // position of the job and its taps; all math wraps at the sample width
  always_comb begin
    n      = job_p_q - POS_W'(job_j_q);
    i_ok   = (job_j_q >= 2'd2) && (n >= 8'd2);
    q_ok   = (job_j_q == LAG_J) && (n >= POS_LAG);
    tap_c  = job_j_q[0] ? dly_q[3] : dly_q[2];
    tap_a  = job_j_q[0] ? dly_q[5] : dly_q[4];
    tap_b  = job_j_q[0] ? dly_q[1] : dly_q[0];
    i_raw  = (tap_c << 3) - ((tap_a + tap_b) << 2);
    q_diff = dly_q[2] - dly_q[4];
    q_raw  = (q_diff << 3) - q_diff + dly_q[6] + dly_q[0];
    i_val  = i_ok ? i_raw : '0;
    q_val  = q_ok ? q_raw : '0;
    if (negate_even_i && n[1]) begin
      i_val = -i_val;
    end
    if (negate_even_i && (n[1] ^ n[0])) begin
      q_val = -q_val;
    end
  end

  assign job_push_o  = busy_q;
  assign job_o.i_val = i_val;
  assign job_o.q_val = q_val;
  assign job_o.last  = flush_q && (job_j_q == '0);

endmodule

`default_nettype wire

/* rtl/core/bpiq_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_sqrt (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bpiq_pkg::sqrt_req_t req_i,
  output bpiq_pkg::sqrt_rsp_t      rsp_o
);

  import bpiq_pkg::*;

  localparam int unsigned ITER  = SAMPLE_BITS;
  localparam int unsigned RAD_W = 2 * SAMPLE_BITS;
  localparam int unsigned REM_W = SAMPLE_BITS + 1;
  localparam int unsigned IT_W  = $clog2(ITER);

  logic [RAD_W-1:0]       rad_q;
  logic [REM_W-1:0]       rem_q;
  logic [SAMPLE_BITS-1:0] root_q;
  logic [IT_W-1:0]        iter_q;
  logic                   busy_q, done_q;

  logic [REM_W+1:0]       rem_sh, trial, diff;
  logic                   fits;

  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= IT_W'(ITER - 1);
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[SAMPLE_BITS-2:0], fits};
      iter_q <= iter_q - IT_W'(1);
      if (iter_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

/* rtl/core/bpiq_back.sv */
// Back end: moving-window sums over a prefix-sum ring, then magnitude.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_back #(
  parameter int unsigned MAX_WINDOW = bpiq_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bpiq_pkg::job_t                 job_i,
  input  wire logic                           job_empty_i,
  output logic                                job_pop_o,
  input  wire logic [bpiq_pkg::WIN_LEN_W-1:0] window_len_i,
  output logic                                res_push_o,
  output bpiq_pkg::out_item_t                 res_o,
  input  wire logic                           res_full_i
);

  import bpiq_pkg::*;

  localparam int unsigned PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 2);
  localparam int unsigned CNT_W  = (FILL_W > WIN_LEN_W) ? FILL_W : WIN_LEN_W;
  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned RAD_W  = 2 * SAMPLE_BITS;

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_READ   = 5'b00010,
    B_SQUARE = 5'b00100,
    B_START  = 5'b01000,
    B_ROOT   = 5'b10000
  } back_state_e;

  back_state_e      state_q;
  logic [PTR_W-1:0] ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic [SB-1:0]    pre_i_q, pre_q_q, sum_i_q, sum_q_q;
  logic [RAD_W-1:0] sq_i_q, sq_q_q;
  logic             zero_q, last_q;

  logic [CNT_W-1:0] win_ext, win_eff, fill_d, cnt, ptr_ext, rd_idx;
  logic [PTR_W-1:0] ptr_d;
  logic [2*SB-1:0]  rd_data;
  logic [SB-1:0]    abs_i, abs_q;
  sqrt_req_t        sq_req;
  sqrt_rsp_t        sq_rsp;

  always_comb begin
    win_ext = CNT_W'(window_len_i);
    if (window_len_i == '0) begin
      win_eff = CNT_W'(1);
    end else if (win_ext > CNT_W'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = win_ext;
    end
    ptr_d   = (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
    // fill stops one past the ring size so "whole frame" stays distinguishable
    fill_d  = (fill_q == CNT_W'(MAX_WINDOW + 1)) ? fill_q : fill_q + CNT_W'(1);
    cnt     = (fill_d < win_eff) ? fill_d : win_eff;
    ptr_ext = CNT_W'(ptr_d);
    rd_idx  = (ptr_ext >= cnt) ? ptr_ext - cnt : ptr_ext + (CNT_W'(MAX_WINDOW) - cnt);
    abs_i   = sum_i_q[SB-1] ? -sum_i_q : sum_i_q;
    abs_q   = sum_q_q[SB-1] ? -sum_q_q : sum_q_q;
  end

  // ring of prefix sums, entry k holds the prefix after k values (mod depth)
  bpiq_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == B_READ),
    .waddr_i (ptr_q),
    .wdata_i ({pre_i_q, pre_q_q}),
    .raddr_i (rd_idx[PTR_W-1:0]),
    .rdata_o (rd_data)
  );

  assign sq_req.start    = (state_q == B_START);
  assign sq_req.radicand = sq_i_q + sq_q_q;

  bpiq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == B_ROOT) && sq_rsp.done && !res_full_i;

  assign res_o.in_phase   = sum_i_q;
  assign res_o.quadrature = sum_q_q;
  assign res_o.magnitude  = (sq_rsp.root > SB'(MAG_MAX)) ? MAG_MAX : sq_rsp.root[MAG_W-1:0];
  assign res_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ptr_q   <= '0;
      fill_q  <= '0;
      pre_i_q <= '0;
      pre_q_q <= '0;
      zero_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            pre_i_q <= pre_i_q + job_i.i_val;
            pre_q_q <= pre_q_q + job_i.q_val;
            ptr_q   <= ptr_d;
            fill_q  <= fill_d;
            zero_q  <= (cnt == fill_d);
            last_q  <= job_i.last;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          if (last_q) begin
            ptr_q   <= '0;
            fill_q  <= '0;
            pre_i_q <= '0;
            pre_q_q <= '0;
          end
          state_q <= B_SQUARE;
        end
        B_SQUARE: state_q <= B_START;
        B_START:  state_q <= B_ROOT;
        B_ROOT: begin
          if (sq_rsp.done && !res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == B_READ) begin
      sum_i_q <= pre_i_q - (zero_q ? '0 : rd_data[2*SB-1:SB]);
      sum_q_q <= pre_q_q - (zero_q ? '0 : rd_data[SB-1:0]);
    end
    if (state_q == B_SQUARE) begin
      sq_i_q <= RAD_W'(abs_i) * RAD_W'(abs_i);
      sq_q_q <= RAD_W'(abs_q) * RAD_W'(abs_q);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bandpass_iq_envelope_demodulator.sv */
// Top level of the bandpass IQ envelope demodulator.
`timescale 1ns / 1ps
`default_nettype none

// Bandpass-sampled echo demodulator. Signed 16-bit samples come in one per
// push transfer; frame_end marks the last sample of a frame. For each frame
// position n the front forms I = 8x[n]-4(x[n-2]+x[n+2]) and
// Q = 7(x[n+1]-x[n-1])+x[n-3]+x[n+3], both wrapped to 16 bits and zero where
// taps fall outside the frame, with optional sign flips (negate_even_mode:
// I negated at n mod 4 = 2,3, Q at n mod 4 = 1,2). The back sums each over
// the last window_len values of the frame (wrapping) and reports
// floor(sqrt(I^2+Q^2)) saturated to 32767. Results lag three samples; the
// frame_end sample flushes the remaining positions (up to four results, the
// final one with last set) and restarts the frame state.
// The front takes a sample and then holds full high while it issues the
// result jobs for it (none for the first three samples of a frame, one for
// each later sample, up to four at frame end), longer while the four-entry
// job queue is full. The back works on one job at a time and takes no new
// job until its result is pushed: job read and prefix update, window
// subtract, squaring, root start, then the square-root iterations, one per
// result bit, and the push of the result (held while the result queue is
// full). The square root sets the sustained rate. The window ring needs no
// clearing pass; it is only read at entries written in the current frame.
// Configuration is taken at any cycle (cfg_ready_o stays high) and must only
// change while the block is idle. Index 0 is window_len (0 acts as 1, above
// MAX_WINDOW clips), index 1 is negate_even_mode; other indexes are ignored.

module bandpass_iq_envelope_demodulator #(
  parameter int unsigned MAX_WINDOW = bpiq_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample side
  input  wire logic                            push,
  output logic                                 full,
  input  wire bpiq_pkg::in_item_t              item_i,
  // result side
  output logic                                 empty,
  input  wire logic                            pop,
  output bpiq_pkg::out_item_t                  result_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpiq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpiq_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bpiq_pkg::*;

  localparam int unsigned JOB_W = $bits(job_t);
  localparam int unsigned RES_W = $bits(out_item_t);

  logic [WIN_LEN_W-1:0] window_len_q;
  logic                 negate_even_q;

  job_t       job_in, job_out;
  logic [JOB_W-1:0] job_out_bits;
  logic       job_push, job_full, job_pop, job_empty;
  out_item_t  res_in;
  logic [RES_W-1:0] res_out_bits;
  logic       res_push, res_full;

  // config registers; a transfer completes on every valid cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q  <= WIN_LEN_RST;
      negate_even_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WINDOW_LEN) begin
        window_len_q <= cfg_data_i[WIN_LEN_W-1:0];
      end else if (cfg_index_i == CFG_NEGATE_EVEN) begin
        negate_even_q <= cfg_data_i[0];
      end
    end
  end

  bpiq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .push          (push),
    .full          (full),
    .negate_even_i (negate_even_q),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .job_full_i    (job_full)
  );

  // decouples the FIR front from the slow magnitude back end
  bpiq_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out_bits),
    .empty_o (job_empty)
  );

  assign job_out = job_t'(job_out_bits);

  bpiq_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .job_empty_i  (job_empty),
    .job_pop_o    (job_pop),
    .window_len_i (window_len_q),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  // finished results wait here so the back end keeps working
  bpiq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty)
  );

  assign result_o = out_item_t'(res_out_bits);

endmodule

`default_nettype wire

/* rtl/core/bpiq_checker.sv */
// Port-level checks for the demodulator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module bpiq_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            push,
  input wire logic                            full,
  input wire bpiq_pkg::in_item_t              item_i,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire bpiq_pkg::out_item_t             result_o,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o
);

  import bpiq_pkg::*;

  logic [SAMPLE_BITS-1:0] abs_i, abs_q;
  logic [MAG_W-1:0]       lim_i, lim_q;

  always_comb begin
    abs_i = result_o.in_phase[SAMPLE_BITS-1] ? -result_o.in_phase : result_o.in_phase;
    abs_q = result_o.quadrature[SAMPLE_BITS-1] ? -result_o.quadrature
                                               : result_o.quadrature;
    lim_i = (abs_i > SAMPLE_BITS'(MAG_MAX)) ? MAG_MAX : abs_i[MAG_W-1:0];
    lim_q = (abs_q > SAMPLE_BITS'(MAG_MAX)) ? MAG_MAX : abs_q[MAG_W-1:0];
  end

  // a frame end always flushes at least one result, so the front stalls
  a_flush_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && item_i.frame_end |=> full)
    else $error("front took a new sample right after a frame end");

  // magnitude can never be below either component
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.magnitude >= lim_i) && (result_o.magnitude >= lim_q))
    else $error("magnitude below |I| or |Q|");

  // a waiting result holds until it is popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed or vanished");

  // config writes never stall
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind bandpass_iq_envelope_demodulator bpiq_checker u_bpiq_checker (.*);

`default_nettype wire
